// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the replay core.
// Depends on nothing; included by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ssor_pkg.sv =====
// Package of the sparse solve op replay core: widths, codes, states, structs.
// No dependencies; used by every module of the block but the vector store.
package ssor_pkg;

  localparam int IDX_W      = 8;
  localparam int Q_W        = 32;
  localparam int FRAC_W     = 16;
  localparam int MODE_W     = 2;
  localparam int STAT_W     = 2;
  localparam int DIFF_W     = 49;
  localparam int S_DATA_W   = 112;
  localparam int M_DATA_W   = 40;
  localparam int DEFAULT_VECTOR_DEPTH = 256;

  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_BACK = 2'd2,
    MODE_READ = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_DIV0 = 2'd1,
    STAT_OVF  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_TGT,
    S_RD_SRC,
    S_MUL,
    S_DIFF,
    S_EVAL,
    S_DIV,
    S_FIN
  } core_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } div_state_t;

  typedef struct packed {
    logic           done;
    logic           ovf;
    logic [Q_W-1:0] value;
  } div_res_t;

endpackage

// ===== rtl/core/ssor_vec_mem.sv =====
// Vector store of the replay core: one write port, one registered read port.
// Depends on nothing but its DEPTH parameter.
module ssor_vec_mem #(
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [31:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [31:0]               rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ssor_div.sv =====
// Iterative signed divider of the replay core: (dividend * 2^16) / divisor,
// truncated toward zero and saturated to 32 bits, one quotient bit per cycle.
// Depends on ssor_pkg.
module ssor_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [ssor_pkg::DIFF_W-1:0]  dividend,
  input  logic signed [ssor_pkg::Q_W-1:0]     divisor,
  output ssor_pkg::div_res_t                  res
);

  localparam int QW    = ssor_pkg::Q_W;
  localparam int DW    = ssor_pkg::DIFF_W;
  localparam int NUM_W = ssor_pkg::DIFF_W + ssor_pkg::FRAC_W;
  localparam int CNT_W = $clog2(QW);

  ssor_pkg::div_state_t state, state_next;

  logic [DW-1:0]     a_mag;
  logic [NUM_W-1:0]  num;
  logic [QW-1:0]     d_mag_in;
  logic              big_in;

  logic              neg;
  logic              big;
  logic [QW-1:0]     d_mag;
  logic [QW-1:0]     rem;
  logic [QW-1:0]     quo;
  logic [CNT_W-1:0]  cnt;

  logic [QW:0]       r2;
  logic [QW:0]       sub;
  logic              ge;

  always_comb begin
    a_mag    = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
    num      = {a_mag, {ssor_pkg::FRAC_W{1'b0}}};
    d_mag_in = divisor[QW-1] ? QW'(-divisor) : QW'(divisor);
    big_in   = num[NUM_W-1:QW] >= {{(NUM_W-2*QW){1'b0}}, d_mag_in};
    r2       = {rem, quo[QW-1]};
    sub      = r2 - {1'b0, d_mag};
    ge       = r2 >= {1'b0, d_mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssor_pkg::D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ssor_pkg::D_IDLE: begin
        if (start) begin
          state_next = big_in ? ssor_pkg::D_DONE : ssor_pkg::D_RUN;
        end
      end
      ssor_pkg::D_RUN: begin
        if (cnt == CNT_W'(QW - 1)) begin
          state_next = ssor_pkg::D_DONE;
        end
      end
      ssor_pkg::D_DONE: begin
        state_next = ssor_pkg::D_IDLE;
      end
      default: begin
        state_next = ssor_pkg::D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ssor_pkg::D_IDLE: begin
        if (start) begin
          neg   <= dividend[DW-1] ^ divisor[QW-1];
          big   <= big_in;
          d_mag <= d_mag_in;
          rem   <= num[2*QW-1:QW];
          quo   <= num[QW-1:0];
          cnt   <= '0;
        end
      end
      ssor_pkg::D_RUN: begin
        rem <= ge ? sub[QW-1:0] : r2[QW-1:0];
        quo <= {quo[QW-2:0], ge};
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.done  = state == ssor_pkg::D_DONE;
    res.ovf   = 1'b0;
    res.value = quo;
    if (big) begin
      res.ovf   = 1'b1;
      res.value = neg ? ssor_pkg::Q_MIN : ssor_pkg::Q_MAX;
    end else if (neg) begin
      if (quo > ssor_pkg::Q_MIN) begin
        res.ovf   = 1'b1;
        res.value = ssor_pkg::Q_MIN;
      end else begin
        res.value = -quo;
      end
    end else if (quo[QW-1]) begin
      res.ovf   = 1'b1;
      res.value = ssor_pkg::Q_MAX;
    end
  end

endmodule

// ===== rtl/core/sparse_solve_op_replay_core.sv =====
// Sparse solve op replay core: sequencer, multiply/subtract datapath and result register.
// Depends on ssor_pkg, ssor_vec_mem and ssor_div.
//
// Usage: each transaction on the s_ channel carries one op (s_tuser selects load,
// forward elimination, back substitution or read). Every op yields exactly one
// transaction on the m_ channel: the entry index, the entry value (signed Q16.16)
// and a status code in m_tuser.
// The block takes one op at a time; s_tready is high only between ops.
// A load goes straight to the result step; a read reads target and source, then
// finishes; a forward op also multiplies, subtracts and evaluates; back substitution
// adds the divide step (skipped with a zero diagonal, and the bit loop skipped when the
// overflow precheck finds the quotient out of range), where the divider makes one
// quotient bit per cycle. s_tready returns on the same edge that raises m_tvalid.
// The vector store is one single-port-read memory, so an op reads target, then source.
// The result sits in an output register: the next op is accepted while it waits,
// and that op stalls in its last step until m_tready frees the register.
// Reset clears the sequencer and the output valid; the store is not cleared, and
// an entry must be loaded before it is read or used by an op.
module sparse_solve_op_replay_core #(
  parameter int VECTOR_DEPTH = ssor_pkg::DEFAULT_VECTOR_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // target_index[7:0], source_index[15:8], coefficient[47:16], diagonal[79:48],
  // load_value[111:80]
  input  logic [ssor_pkg::S_DATA_W-1:0]   s_tdata,
  // mode[1:0]
  input  logic [ssor_pkg::MODE_W-1:0]     s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // entry_index[7:0], entry_value[39:8]
  output logic [ssor_pkg::M_DATA_W-1:0]   m_tdata,
  // status[1:0]
  output logic [ssor_pkg::STAT_W-1:0]     m_tuser
);

  localparam int ADDR_W = $clog2(VECTOR_DEPTH);
  localparam int IW     = ssor_pkg::IDX_W;
  localparam int QW     = ssor_pkg::Q_W;
  localparam int DW     = ssor_pkg::DIFF_W;

  ssor_pkg::core_state_t state, state_next;

  ssor_pkg::mode_t          mode_r;
  logic [IW-1:0]            tgt;
  logic [IW-1:0]            src;
  logic signed [QW-1:0]     coef;
  logic signed [QW-1:0]     diag;
  logic [QW-1:0]            res;
  ssor_pkg::status_t        stat;
  logic signed [QW-1:0]     t_val;
  logic signed [2*QW-1:0]   prod;
  logic signed [DW-1:0]     diff;

  logic                     tgt_ok;
  logic                     src_ok;
  logic                     diag_zero;
  logic                     out_free;
  logic signed [QW-1:0]     s_op;
  logic [QW-1:0]            rd_val;
  logic                     ovf_hi;
  logic                     ovf_lo;

  logic                     rd_tgt;
  logic                     div_start;
  logic                     mem_we;
  logic                     out_load;

  logic [ADDR_W-1:0]        raddr;
  logic [QW-1:0]            rdata;
  ssor_pkg::div_res_t       div_res;

  assign tgt_ok    = 32'(tgt) < 32'(VECTOR_DEPTH);
  assign src_ok    = 32'(src) < 32'(VECTOR_DEPTH);
  assign diag_zero = diag == '0;
  assign out_free  = !m_tvalid || m_tready;
  assign raddr     = rd_tgt ? ADDR_W'(tgt) : ADDR_W'(src);
  assign rd_val    = tgt_ok ? rdata : '0;
  assign s_op      = src_ok ? rdata : '0;
  assign ovf_hi    = !diff[DW-1] && (|diff[DW-2:QW-1]);
  assign ovf_lo    = diff[DW-1] && !(&diff[DW-2:QW-1]);

  ssor_vec_mem #(
    .DEPTH (VECTOR_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ADDR_W'(tgt)),
    .wdata (res),
    .raddr (raddr),
    .rdata (rdata)
  );

  ssor_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (diag),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssor_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ssor_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = (ssor_pkg::mode_t'(s_tuser) == ssor_pkg::MODE_LOAD) ?
                       ssor_pkg::S_FIN : ssor_pkg::S_RD_TGT;
        end
      end
      ssor_pkg::S_RD_TGT: state_next = ssor_pkg::S_RD_SRC;
      ssor_pkg::S_RD_SRC: begin
        state_next = (mode_r == ssor_pkg::MODE_READ) ? ssor_pkg::S_FIN : ssor_pkg::S_MUL;
      end
      ssor_pkg::S_MUL:    state_next = ssor_pkg::S_DIFF;
      ssor_pkg::S_DIFF:   state_next = ssor_pkg::S_EVAL;
      ssor_pkg::S_EVAL: begin
        state_next = (mode_r == ssor_pkg::MODE_BACK && !diag_zero) ?
                     ssor_pkg::S_DIV : ssor_pkg::S_FIN;
      end
      ssor_pkg::S_DIV: begin
        if (div_res.done) begin
          state_next = ssor_pkg::S_FIN;
        end
      end
      ssor_pkg::S_FIN: begin
        if (out_free) begin
          state_next = ssor_pkg::S_IDLE;
        end
      end
      default: state_next = ssor_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    rd_tgt    = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ssor_pkg::S_IDLE:   s_tready = 1'b1;
      ssor_pkg::S_RD_TGT: rd_tgt = 1'b1;
      ssor_pkg::S_EVAL:   div_start = (mode_r == ssor_pkg::MODE_BACK) && !diag_zero;
      ssor_pkg::S_FIN: begin
        out_load = out_free;
        mem_we   = out_free && (mode_r != ssor_pkg::MODE_READ) && tgt_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ssor_pkg::S_IDLE: begin
        if (s_tvalid) begin
          mode_r <= ssor_pkg::mode_t'(s_tuser);
          tgt    <= s_tdata[7:0];
          src    <= s_tdata[15:8];
          coef   <= s_tdata[47:16];
          diag   <= s_tdata[79:48];
          res    <= s_tdata[111:80];
          stat   <= ssor_pkg::STAT_OK;
        end
      end
      ssor_pkg::S_RD_SRC: begin
        t_val <= rd_val;
        res   <= rd_val;
      end
      ssor_pkg::S_MUL: begin
        prod <= s_op * coef;
      end
      ssor_pkg::S_DIFF: begin
        diff <= DW'(t_val) - DW'(prod >>> ssor_pkg::FRAC_W);
      end
      ssor_pkg::S_EVAL: begin
        if (mode_r == ssor_pkg::MODE_FWD) begin
          if (ovf_hi) begin
            res  <= ssor_pkg::Q_MAX;
            stat <= ssor_pkg::STAT_OVF;
          end else if (ovf_lo) begin
            res  <= ssor_pkg::Q_MIN;
            stat <= ssor_pkg::STAT_OVF;
          end else begin
            res <= diff[QW-1:0];
          end
        end else if (diag_zero) begin
          res  <= diff[DW-1] ? ssor_pkg::Q_MIN : ssor_pkg::Q_MAX;
          stat <= ssor_pkg::STAT_DIV0;
        end
      end
      ssor_pkg::S_DIV: begin
        if (div_res.done) begin
          res  <= div_res.value;
          stat <= div_res.ovf ? ssor_pkg::STAT_OVF : ssor_pkg::STAT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {res, tgt};
      m_tuser <= stat;
    end
  end

endmodule

// ===== rtl/core/ssor_port_chk.sv =====
// Port checker of the sparse solve op replay core, bound to the top level.
// Depends on ssor_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ssor_port_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [ssor_pkg::S_DATA_W-1:0]   s_tdata,
  input logic [ssor_pkg::MODE_W-1:0]     s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ssor_pkg::M_DATA_W-1:0]   m_tdata,
  input logic [ssor_pkg::STAT_W-1:0]     m_tuser
);

  `ASSERT_NEXT(a_one_op_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "ready after accept")
  `ASSERT_IMPL(a_ovf_saturates, clk, rst, m_tvalid && m_tuser == ssor_pkg::STAT_OVF, m_tdata[39:8] == ssor_pkg::Q_MAX || m_tdata[39:8] == ssor_pkg::Q_MIN, "overflow not saturated")
  `ASSERT_IMPL(a_div0_saturates, clk, rst, m_tvalid && m_tuser == ssor_pkg::STAT_DIV0, m_tdata[39:8] == ssor_pkg::Q_MAX || m_tdata[39:8] == ssor_pkg::Q_MIN, "zero divisor not saturated")
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind sparse_solve_op_replay_core ssor_port_chk u_port_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/sv/sparse_solve_op_replay_core_tb.sv =====
// Self-checking testbench for sparse_solve_op_replay_core: directed, backpressure and
// random op replays checked against an in-bench predictor of the vector store.
// Depends on ssor_pkg and the core RTL; nothing else.
module sparse_solve_op_replay_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

  typedef struct packed {
    ssor_pkg::mode_t mode;
    logic [7:0]      target;
    logic [7:0]      source;
    logic [31:0]     coefficient;
    logic [31:0]     diagonal;
    logic [31:0]     load_value;
  } op_t;

  typedef struct packed {
    logic [7:0]        index;
    logic [31:0]       value;
    ssor_pkg::status_t status;
  } entry_result_t;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [ssor_pkg::S_DATA_W-1:0]   s_tdata;
  logic [ssor_pkg::MODE_W-1:0]     s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [ssor_pkg::M_DATA_W-1:0]   m_tdata;
  logic [ssor_pkg::STAT_W-1:0]     m_tuser;

  logic [31:0]   vector_copy [0:255];
  logic [255:0]  is_loaded;
  int            loaded_list[$];
  entry_result_t pending_entries[$];
  entry_result_t oldest_entry;
  int            fail_count;
  int            cycle_count;
  int            burst_left;
  bit            gaps_on;
  int            rx_mode;
  logic [7:0]    rx_pattern;
  int            hold_request;
  int            hold_left;

  sparse_solve_op_replay_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] saturate_q(input logic signed [127:0] x, output logic ovf);
    ovf = 1'b0;
    if (x > SAT_HI) begin
      ovf = 1'b1;
      return ssor_pkg::Q_MAX;
    end
    if (x < SAT_LO) begin
      ovf = 1'b1;
      return ssor_pkg::Q_MIN;
    end
    return x[31:0];
  endfunction

  function automatic entry_result_t predict_entry(input op_t op);
    entry_result_t       r;
    logic signed [63:0]  tval;
    logic signed [63:0]  sval;
    logic signed [63:0]  cval;
    logic signed [63:0]  diff;
    logic signed [127:0] scaled;
    logic signed [127:0] divisor;
    logic                ovf;
    r.index  = op.target;
    r.status = ssor_pkg::STAT_OK;
    case (op.mode)
      ssor_pkg::MODE_LOAD: begin
        r.value = op.load_value;
      end
      ssor_pkg::MODE_READ: begin
        r.value = vector_copy[op.target];
      end
      default: begin
        tval = $signed(vector_copy[op.target]);
        sval = $signed(vector_copy[op.source]);
        cval = $signed(op.coefficient);
        diff = tval - ((sval * cval) >>> 16);
        if (op.mode == ssor_pkg::MODE_FWD) begin
          r.value = saturate_q(128'(diff), ovf);
          if (ovf) r.status = ssor_pkg::STAT_OVF;
        end else if (op.diagonal == 32'd0) begin
          r.status = ssor_pkg::STAT_DIV0;
          r.value  = (diff < 0) ? ssor_pkg::Q_MIN : ssor_pkg::Q_MAX;
        end else begin
          scaled  = diff;
          scaled  = scaled <<< 16;
          divisor = $signed(op.diagonal);
          r.value = saturate_q(scaled / divisor, ovf);
          if (ovf) r.status = ssor_pkg::STAT_OVF;
        end
      end
    endcase
    if (op.mode != ssor_pkg::MODE_READ) vector_copy[op.target] = r.value;
    return r;
  endfunction

  function automatic op_t make_op(input ssor_pkg::mode_t mode, input int tgt, input int src,
                                  input logic [31:0] coef, input logic [31:0] diag,
                                  input logic [31:0] lval);
    op_t op;
    op.mode        = mode;
    op.target      = 8'(tgt);
    op.source      = 8'(src);
    op.coefficient = coef;
    op.diagonal    = diag;
    op.load_value  = lval;
    return op;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return ssor_pkg::Q_MAX;
      1:       return ssor_pkg::Q_MIN;
      2, 3, 4: return $urandom;
      default: return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? ssor_pkg::Q_MAX : ssor_pkg::Q_MIN;
      1, 2:    return $urandom;
      3:       return 32'd0;
      default: return 32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_diag();
    logic [31:0] mag;
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1, 2:    return $urandom;
      3:       return ($urandom_range(0, 1) != 0) ? 32'h0000_0001 : 32'hFFFF_FFFF;
      default: begin
        mag = 32'($urandom_range(32'h0000_4000, 32'h0008_0000));
        return ($urandom_range(0, 1) != 0) ? mag : -mag;
      end
    endcase
  endfunction

  function automatic op_t random_op();
    op_t op;
    int  pick;
    pick           = $urandom_range(0, 99);
    op.target      = 8'($urandom);
    op.source      = 8'($urandom);
    op.coefficient = rand_coef();
    op.diagonal    = rand_diag();
    op.load_value  = rand_value();
    if (pick < 25 || loaded_list.size() < 4) op.mode = ssor_pkg::MODE_LOAD;
    else if (pick < 55) op.mode = ssor_pkg::MODE_FWD;
    else if (pick < 80) op.mode = ssor_pkg::MODE_BACK;
    else op.mode = ssor_pkg::MODE_READ;
    if (op.mode != ssor_pkg::MODE_LOAD) begin
      op.target = 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
      if (op.mode != ssor_pkg::MODE_READ) begin
        if ($urandom_range(0, 9) == 0) op.source = op.target;
        else op.source = 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
      end
    end
    return op;
  endfunction

  task automatic pace_sender();
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    s_tvalid = 1'b0;
    repeat ($urandom_range(1, 12)) @(negedge clk);
    burst_left = $urandom_range(0, 15);
  endtask

  task automatic send_op(input op_t op);
    s_tvalid = 1'b1;
    s_tdata  = {op.load_value, op.diagonal, op.coefficient, op.source, op.target};
    s_tuser  = op.mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op.mode == ssor_pkg::MODE_LOAD && !is_loaded[op.target]) begin
      is_loaded[op.target] = 1'b1;
      loaded_list.insert(loaded_list.size(), int'(op.target));
    end
    pending_entries.insert(pending_entries.size(), predict_entry(op));
    @(negedge clk);
    pace_sender();
  endtask

  task automatic test_directed_ops();
    gaps_on = 1'b1;
    rx_mode = 1;
    send_op(make_op(ssor_pkg::MODE_LOAD, 0, 0, 32'd0, 32'd0, ssor_pkg::Q_MAX));
    send_op(make_op(ssor_pkg::MODE_LOAD, 255, 0, 32'd0, 32'd0, ssor_pkg::Q_MIN));
    send_op(make_op(ssor_pkg::MODE_LOAD, 1, 0, 32'd0, 32'd0, 32'd0));
    send_op(make_op(ssor_pkg::MODE_LOAD, 2, 0, 32'd0, 32'd0, 32'h0001_0000));
    send_op(make_op(ssor_pkg::MODE_LOAD, 3, 0, 32'd0, 32'd0, 32'hFFFF_0000));
    send_op(make_op(ssor_pkg::MODE_LOAD, 4, 0, 32'd0, 32'd0, 32'h0005_0000));
    send_op(make_op(ssor_pkg::MODE_LOAD, 5, 0, 32'd0, 32'd0, 32'hFFFD_0000));
    send_op(make_op(ssor_pkg::MODE_LOAD, 6, 0, 32'd0, 32'd0, 32'd0));
    send_op(make_op(ssor_pkg::MODE_LOAD, 7, 0, 32'd0, 32'd0, 32'h0001_0000));
    send_op(make_op(ssor_pkg::MODE_READ, 0, 255, ssor_pkg::Q_MAX, ssor_pkg::Q_MIN,
                    ssor_pkg::Q_MIN));
    send_op(make_op(ssor_pkg::MODE_READ, 255, 0, 32'd0, 32'd0, 32'd0));
    send_op(make_op(ssor_pkg::MODE_FWD, 1, 2, 32'h0002_0000, 32'd0, 32'd0));
    send_op(make_op(ssor_pkg::MODE_FWD, 0, 3, 32'h0001_0000, 32'd0, 32'd0));
    send_op(make_op(ssor_pkg::MODE_FWD, 255, 2, 32'h0001_0000, 32'd0, 32'd0));
    send_op(make_op(ssor_pkg::MODE_FWD, 7, 255, ssor_pkg::Q_MIN, 32'd0, 32'd0));
    send_op(make_op(ssor_pkg::MODE_FWD, 3, 3, ssor_pkg::Q_MAX, 32'd0, 32'd0));
    send_op(make_op(ssor_pkg::MODE_FWD, 2, 2, 32'h0000_8000, 32'd0, 32'd0));
    send_op(make_op(ssor_pkg::MODE_BACK, 4, 3, 32'h0001_0000, 32'h0002_0000, 32'd0));
    send_op(make_op(ssor_pkg::MODE_BACK, 4, 1, 32'd0, 32'd0, 32'd0));
    send_op(make_op(ssor_pkg::MODE_BACK, 5, 1, 32'd0, 32'd0, 32'd0));
    send_op(make_op(ssor_pkg::MODE_BACK, 6, 6, 32'd0, 32'd0, 32'd0));
    send_op(make_op(ssor_pkg::MODE_BACK, 0, 1, 32'd0, 32'h0000_0001, 32'd0));
    send_op(make_op(ssor_pkg::MODE_BACK, 255, 1, 32'd0, 32'hFFFF_FFFF, 32'd0));
    send_op(make_op(ssor_pkg::MODE_READ, 4, 0, 32'd0, 32'd0, 32'd0));
  endtask

  task automatic test_long_stall();
    gaps_on      = 1'b0;
    hold_request = 400;
    repeat (20) send_op(random_op());
  endtask

  task automatic test_random_replay(input int n, input int rx_sel, input bit gaps);
    gaps_on    = gaps;
    rx_mode    = rx_sel;
    rx_pattern = 8'($urandom_range(1, 255));
    repeat (n) send_op(random_op());
  endtask

  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        case (rx_mode)
          0:       m_tready = 1'b1;
          1:       m_tready = ($urandom_range(0, 9) < 6);
          default: begin
            m_tready   = rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_entries.size() == 0) begin
        $error("result with no op outstanding: entry_index %0d", m_tdata[7:0]);
        fail_count++;
      end else begin
        oldest_entry = pending_entries.pop_front();
        if (m_tdata[7:0] !== oldest_entry.index) begin
          $error("entry_index expected %0d actual %0d", oldest_entry.index, m_tdata[7:0]);
          fail_count++;
        end
        if (m_tdata[39:8] !== oldest_entry.value) begin
          $error("entry_value expected %h actual %h", oldest_entry.value, m_tdata[39:8]);
          fail_count++;
        end
        if (m_tuser !== oldest_entry.status) begin
          $error("status expected %0d actual %0d", oldest_entry.status, m_tuser);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = ssor_pkg::MODE_LOAD;
    is_loaded    = '0;
    fail_count   = 0;
    cycle_count  = 0;
    burst_left   = 0;
    gaps_on      = 1'b0;
    rx_mode      = 0;
    rx_pattern   = 8'hA5;
    hold_request = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_ops();
    test_long_stall();
    test_random_replay(480, 0, 1'b0);
    test_random_replay(480, 1, 1'b1);
    test_random_replay(480, 2, 1'b1);
    test_random_replay(470, 1, 1'b0);

    s_tvalid = 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_entries.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
